// ===== design/ers_pkg.sv =====
package ers_pkg;

   localparam int unsigned TIME_BITS = 32;
   localparam int unsigned PICK_BITS = 3;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   localparam int unsigned REG_POLICY    = 0;
   localparam int unsigned REG_TASK_BASE = 1;

   typedef enum logic {
      POLICY_EDF = 1'b0,
      POLICY_RM  = 1'b1
   } policy_type;

   typedef struct packed {
      logic                 found;
      logic [PICK_BITS-1:0] pick;
      logic [TIME_BITS-1:0] key;
      logic                 done;
   } link_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      sat_add = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

endpackage

// ===== design/edf_rm_task_scheduler_core.sv =====
// A tick beat's response is captured in the response register when the beat is accepted.
// Throughput: one tick per cycle while the response is taken; the task cells form one compare chain and
// all task state updates in the same cycle, so ticks stream back to back.
// req_ready stays high while the response register is empty or being taken.
// Reset (synchronous, active high) clears time, task state, timing and policy.
module edf_rm_task_scheduler_core #(
   parameter int unsigned TASKS       = 3,
   parameter int unsigned TIMING_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_running_task,
   output logic                         rsp_idle,
   output logic                         rsp_job_finished,
   output logic [31:0]                  rsp_tick_time,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [$clog2(TASKS+1)-1:0]   csr_index,
   input  logic [3*TIMING_BITS-1:0]     csr_wdata
);

   localparam int unsigned CSR_IDX_BITS = $clog2(TASKS+1);

   ers_pkg::link_type             link [TASKS+1];
   ers_pkg::policy_type           policy_ff, policy_in;
   logic [ers_pkg::TIME_BITS-1:0] time_ff, time_in, now;
   logic                          step, csr_we;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    running_ff;
   logic                          idle_ff, finished_ff;
   logic [31:0]                   tick_ff;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign now       = req_restart ? '0 : time_ff;
   assign link[0]   = '0;

   for (genvar k = 0; k < TASKS; k++) begin : g_cell
      logic cell_we, cell_grant;
      assign cell_we    = csr_we &&
                          csr_index == (CSR_IDX_BITS)'(k + ers_pkg::REG_TASK_BASE);
      assign cell_grant = link[TASKS].found &&
                          link[TASKS].pick == (ers_pkg::PICK_BITS)'(k);
      ers_cell #(
         .INDEX       (k),
         .TIMING_BITS (TIMING_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cfg_we   (cell_we),
         .cfg_data (csr_wdata),
         .policy   (policy_ff),
         .now      (now),
         .restart  (req_restart),
         .step     (step),
         .grant    (cell_grant),
         .link_in  (link[k]),
         .link_out (link[k+1])
      );
   end

   always_comb begin
      policy_in = policy_ff;
      if (csr_we && csr_index == (CSR_IDX_BITS)'(ers_pkg::REG_POLICY)) begin
         policy_in = ers_pkg::policy_type'(csr_wdata[0]);
      end
      time_in = time_ff;
      if (step) begin
         time_in = (now == ers_pkg::TIME_MAX) ? ers_pkg::TIME_MAX : now + 1'b1;
      end
      rsp_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= ers_pkg::POLICY_EDF;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         running_ff  <= link[TASKS].found ? link[TASKS].pick[1:0] : 2'b00;
         idle_ff     <= !link[TASKS].found;
         finished_ff <= link[TASKS].found && link[TASKS].done;
         tick_ff     <= now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = running_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_job_finished = finished_ff;
   assign rsp_tick_time    = tick_ff;

endmodule

// ===== design/ers_cell.sv =====
module ers_cell #(
   parameter int unsigned INDEX       = 0,
   parameter int unsigned TIMING_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cfg_we,
   input  logic [3*TIMING_BITS-1:0]          cfg_data,
   input  ers_pkg::policy_type               policy,
   input  logic [ers_pkg::TIME_BITS-1:0]     now,
   input  logic                              restart,
   input  logic                              step,
   input  logic                              grant,
   input  ers_pkg::link_type                 link_in,
   output ers_pkg::link_type                 link_out
);

   localparam logic [ers_pkg::PICK_BITS-1:0] CELL_PICK = (ers_pkg::PICK_BITS)'(INDEX);

   logic [3*TIMING_BITS-1:0]      timing_ff, timing_in;
   logic [ers_pkg::TIME_BITS-1:0] release_ff, release_in;
   logic [ers_pkg::TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [TIMING_BITS-1:0]        count_ff, count_in;

   logic [TIMING_BITS-1:0]        period, exec_time, rel_deadline;
   logic [ers_pkg::TIME_BITS-1:0] eff_release, eff_deadline, new_release, key;
   logic [TIMING_BITS-1:0]        eff_count, count_inc;
   logic                          ready, done, take;

   assign period       = timing_ff[TIMING_BITS-1:0];
   assign exec_time    = timing_ff[2*TIMING_BITS-1:TIMING_BITS];
   assign rel_deadline = timing_ff[3*TIMING_BITS-1:2*TIMING_BITS];

   always_comb begin
      eff_release  = restart ? '0 : release_ff;
      eff_deadline = restart ? (ers_pkg::TIME_BITS)'(rel_deadline) : deadline_ff;
      eff_count    = restart ? '0 : count_ff;
      count_inc    = eff_count + 1'b1;
      done         = count_inc >= exec_time;
      new_release  = ers_pkg::sat_add(eff_release, (ers_pkg::TIME_BITS)'(period));
      ready        = (exec_time != '0) && (now >= eff_release);
      key          = (policy == ers_pkg::POLICY_RM) ? (ers_pkg::TIME_BITS)'(period)
                                                    : eff_deadline;
      take         = ready && (!link_in.found || key < link_in.key);
      link_out     = link_in;
      if (take) begin
         link_out.found = 1'b1;
         link_out.pick  = CELL_PICK;
         link_out.key   = key;
         link_out.done  = done;
      end
   end

   always_comb begin
      timing_in   = cfg_we ? cfg_data : timing_ff;
      release_in  = release_ff;
      deadline_in = deadline_ff;
      count_in    = count_ff;
      if (step) begin
         release_in  = eff_release;
         deadline_in = eff_deadline;
         count_in    = eff_count;
         if (grant) begin
            if (done) begin
               count_in    = '0;
               release_in  = new_release;
               deadline_in = ers_pkg::sat_add(new_release,
                                              (ers_pkg::TIME_BITS)'(rel_deadline));
            end else begin
               count_in = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff   <= '0;
         release_ff  <= '0;
         deadline_ff <= '0;
         count_ff    <= '0;
      end else begin
         timing_ff   <= timing_in;
         release_ff  <= release_in;
         deadline_ff <= deadline_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== design/ers_checker.sv =====
module ers_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_restart,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_running_task,
   input logic        rsp_idle,
   input logic        rsp_job_finished,
   input logic [31:0] rsp_tick_time
);

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> rsp_running_task == 2'b00 && !rsp_job_finished)
      else $error("idle beat carries a task or a finish");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> rsp_valid && rsp_tick_time == '0)
      else $error("restart beat did not report tick zero");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty response register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tick_time)
                                  && $stable(rsp_running_task))
      else $error("stalled response beat changed");

endmodule

bind edf_rm_task_scheduler_core ers_checker u_ers_checker (.*);
